### rtl/core/rfbcmp_pkg.sv
package rfbcmp_pkg;

   // client message type bytes
   localparam logic [2:0] TYPE_FORMAT    = 3'd0;
   localparam logic [2:0] TYPE_ENCODINGS = 3'd2;
   localparam logic [2:0] TYPE_UPDATE    = 3'd3;
   localparam logic [2:0] TYPE_KEY       = 3'd4;
   localparam logic [2:0] TYPE_POINTER   = 3'd5;
   localparam logic [2:0] TYPE_CUT       = 3'd6;

   // result kinds
   localparam logic [2:0] KIND_FORMAT   = 3'd0;
   localparam logic [2:0] KIND_ENCODING = 3'd1;
   localparam logic [2:0] KIND_UPDATE   = 3'd2;
   localparam logic [2:0] KIND_KEY      = 3'd3;
   localparam logic [2:0] KIND_POINTER  = 3'd4;
   localparam logic [2:0] KIND_CUT      = 3'd5;
   localparam logic [2:0] KIND_ERROR    = 3'd6;

   // message lengths including the type byte
   localparam logic [4:0] LEN_FORMAT     = 5'd20;
   localparam logic [4:0] LEN_UPDATE     = 5'd10;
   localparam logic [4:0] LEN_KEY        = 5'd8;
   localparam logic [4:0] LEN_POINTER    = 5'd6;
   localparam logic [4:0] LEN_CUT        = 5'd8;
   localparam logic [4:0] LEN_ENC_HEADER = 5'd4;
   localparam logic [4:0] LEN_ENC_ENTRY  = 5'd8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic [7:0] data;
      logic       type_ok;
   } byte_item_type;

   typedef enum logic [2:0] {
      PH_TYPE = 3'b001,
      PH_BODY = 3'b010,
      PH_HALT = 3'b100
   } phase_type;

endpackage

### rtl/core/rfbcmp_front.sv
module rfbcmp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   output logic                      push_valid,
   input  logic                      push_ready,
   output rfbcmp_pkg::byte_item_type push_item
);

   logic                      valid_ff, valid_in;
   rfbcmp_pkg::byte_item_type item_ff, item_in;
   logic                      load;

   assign req_tready = !valid_ff || push_ready;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      item_in.data    = req_tdata;
      // known type codes: 0 and 2..6
      item_in.type_ok = (req_tdata == 8'd0) ||
                        ((req_tdata >= 8'd2) && (req_tdata <= 8'd6));
      if (load) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

### rtl/core/rfbcmp_queue.sv
module rfbcmp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rfbcmp_pkg::byte_item_type in_item,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rfbcmp_pkg::byte_item_type out_item
);

   rfbcmp_pkg::byte_item_type mem_ff [rfbcmp_pkg::QUEUE_DEPTH];
   logic [rfbcmp_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rfbcmp_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rfbcmp_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready  = count_ff != rfbcmp_pkg::QUEUE_CNT_W'(rfbcmp_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

### rtl/core/rfbcmp_back.sv
module rfbcmp_back #(
   parameter int MAX_ENCODINGS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   output logic                      item_ready,
   input  rfbcmp_pkg::byte_item_type item,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [2:0]                rsp_kind
);

   localparam logic [16:0] MaxEnc = 17'(MAX_ENCODINGS);

   rfbcmp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  msg_type_ff, msg_type_in;
   logic [4:0]  byte_pos_ff, byte_pos_in;
   logic [15:0] enc_total_ff, enc_total_in;
   logic [15:0] enc_index_ff, enc_index_in;
   logic [7:0]  prev_byte_ff;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_kind_ff, out_kind_in;

   logic        pop;
   logic        emit;
   logic [2:0]  emit_kind;
   logic [4:0]  pos;
   logic [15:0] next_index;
   logic [15:0] header_count;
   logic        shown;

   assign item_ready   = !out_valid_ff || rsp_tready;
   assign pop          = item_valid && item_ready;
   assign pos          = byte_pos_ff + 5'd1;
   assign next_index   = enc_index_ff + 16'd1;
   assign header_count = {prev_byte_ff, item.data};
   assign shown        = {1'b0, enc_index_ff} < MaxEnc;

   always_comb begin
      phase_in     = phase_ff;
      msg_type_in  = msg_type_ff;
      byte_pos_in  = byte_pos_ff;
      enc_total_in = enc_total_ff;
      enc_index_in = enc_index_ff;
      emit         = 1'b0;
      emit_kind    = rfbcmp_pkg::KIND_ERROR;
      if (pop) begin
         unique case (phase_ff)
            rfbcmp_pkg::PH_TYPE: begin
               if (item.type_ok) begin
                  msg_type_in = item.data[2:0];
                  byte_pos_in = 5'd1;
                  phase_in    = rfbcmp_pkg::PH_BODY;
               end else begin
                  emit      = 1'b1;
                  emit_kind = rfbcmp_pkg::KIND_ERROR;
                  phase_in  = rfbcmp_pkg::PH_HALT;
               end
            end
            rfbcmp_pkg::PH_BODY: begin
               byte_pos_in = pos;
               case (msg_type_ff)
                  rfbcmp_pkg::TYPE_FORMAT: begin
                     if (pos >= rfbcmp_pkg::LEN_FORMAT) begin
                        emit      = 1'b1;
                        emit_kind = rfbcmp_pkg::KIND_FORMAT;
                     end
                  end
                  rfbcmp_pkg::TYPE_ENCODINGS: begin
                     if (pos == rfbcmp_pkg::LEN_ENC_HEADER) begin
                        enc_total_in = header_count;
                        enc_index_in = '0;
                        if (header_count == '0) begin
                           emit      = 1'b1;
                           emit_kind = rfbcmp_pkg::KIND_ENCODING;
                           phase_in  = rfbcmp_pkg::PH_TYPE;
                        end
                     end else if (pos >= rfbcmp_pkg::LEN_ENC_ENTRY) begin
                        enc_index_in = next_index;
                        emit         = shown;
                        emit_kind    = rfbcmp_pkg::KIND_ENCODING;
                        if (next_index >= enc_total_ff) begin
                           phase_in = rfbcmp_pkg::PH_TYPE;
                        end else begin
                           // next encoding entry starts after the header
                           byte_pos_in = rfbcmp_pkg::LEN_ENC_HEADER;
                        end
                     end
                  end
                  rfbcmp_pkg::TYPE_UPDATE: begin
                     if (pos >= rfbcmp_pkg::LEN_UPDATE) begin
                        emit      = 1'b1;
                        emit_kind = rfbcmp_pkg::KIND_UPDATE;
                     end
                  end
                  rfbcmp_pkg::TYPE_KEY: begin
                     if (pos >= rfbcmp_pkg::LEN_KEY) begin
                        emit      = 1'b1;
                        emit_kind = rfbcmp_pkg::KIND_KEY;
                     end
                  end
                  rfbcmp_pkg::TYPE_POINTER: begin
                     if (pos >= rfbcmp_pkg::LEN_POINTER) begin
                        emit      = 1'b1;
                        emit_kind = rfbcmp_pkg::KIND_POINTER;
                     end
                  end
                  rfbcmp_pkg::TYPE_CUT: begin
                     if (pos >= rfbcmp_pkg::LEN_CUT) begin
                        emit      = 1'b1;
                        emit_kind = rfbcmp_pkg::KIND_CUT;
                     end
                  end
                  default: begin
                     emit      = 1'b1;
                     emit_kind = rfbcmp_pkg::KIND_ERROR;
                     phase_in  = rfbcmp_pkg::PH_HALT;
                  end
               endcase
               // a completed message returns to waiting for a type byte;
               // the encoding list picks its own next phase
               if (emit && (phase_in == rfbcmp_pkg::PH_BODY) &&
                   (msg_type_ff != rfbcmp_pkg::TYPE_ENCODINGS)) begin
                  phase_in = rfbcmp_pkg::PH_TYPE;
               end
            end
            rfbcmp_pkg::PH_HALT: begin
               // bytes are drained and dropped until reset
            end
            default: begin
               phase_in = rfbcmp_pkg::PH_HALT;
            end
         endcase
      end

      out_kind_in = out_kind_ff;
      if (pop && emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = emit_kind;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rfbcmp_pkg::PH_TYPE;
         msg_type_ff  <= '0;
         byte_pos_ff  <= '0;
         enc_index_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         msg_type_ff  <= msg_type_in;
         byte_pos_ff  <= byte_pos_in;
         enc_index_ff <= enc_index_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      enc_total_ff <= enc_total_in;
      out_kind_ff  <= out_kind_in;
      if (pop) begin
         prev_byte_ff <= item.data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kind   = out_kind_ff;

endmodule

### rtl/core/remote_framebuffer_client_message_parser.sv
// channel | ports        | tdata fields (low bit up)
// --------+--------------+---------------------------------
// input   | req_tvalid,  | in_byte [7:0]
//         | req_tready   |
// result  | rsp_tvalid,  | msg_kind [2:0], zeros [7:3]
//         | rsp_tready   |
//
// one byte is taken every cycle unless the queue backs up; a result word passes
// the input register, queue and result register after its last byte is taken
// the parser state machine handles one byte per cycle unless a result stalls, which sets the rate
// reset is synchronous and clears all control state, no clearing pass
// a stalled result holds only the parser; bytes keep entering until the
// four-entry queue and the input register are full
module remote_framebuffer_client_message_parser #(
   parameter int MAX_ENCODINGS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte [7:0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // msg_kind [2:0], zero [7:3]
);

   rfbcmp_pkg::byte_item_type push_item, pop_item;
   logic push_valid, push_ready, pop_valid, pop_ready;
   logic [2:0] rsp_kind;

   rfbcmp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   rfbcmp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_item  (pop_item)
   );

   rfbcmp_back #(
      .MAX_ENCODINGS (MAX_ENCODINGS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item_ready (pop_ready),
      .item       (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_kind)
   );

   assign rsp_tdata = {5'd0, rsp_kind};

endmodule

### rtl/core/rfbcmp_checker.sv
module rfbcmp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   logic [2:0] kind;
   assign kind = rsp_tdata[2:0];

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:3] == 5'd0)
      else $error("result word has nonzero pad bits");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> kind != 3'd7)
      else $error("result kind out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // after an error word nothing else is produced until reset
   a_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && kind == rfbcmp_pkg::KIND_ERROR |=> !rsp_tvalid)
      else $error("result after error word");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result right after reset");

endmodule

bind remote_framebuffer_client_message_parser rfbcmp_checker u_rfbcmp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
